// ===== rtl/per_cpu_boost_load_tracker_macros.svh =====
// Assertion macros shared by the checker files of the boost load tracker.
// Included by bare file name; holds macro definitions only.
`ifndef PER_CPU_BOOST_LOAD_TRACKER_MACROS_SVH
`define PER_CPU_BOOST_LOAD_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PCBLT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcblt assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PCBLT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcblt assertion failed");

`endif

// ===== rtl/pcblt_pkg.sv =====
// Package of the per-CPU boost load tracker: payload and internal types,
// register codes, reset values and reciprocal constants. No dependencies.
package pcblt_pkg;

   // Table size; the index width must not exceed the cpu_index field.
   localparam int CPU_COUNT  = 8;
   localparam int CPU_IDX_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

   // Field widths.
   localparam int LOAD_W     = 30;
   localparam int RATE_W     = 10;
   localparam int TIME_W     = 64;
   localparam int DEMAND_W   = 32;
   localparam int FACTOR_W   = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 30;

   // Command codes.
   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_RATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TIME  = 2'd2;

   // Register reset values.
   localparam longint NS_PER_MS        = 1000000;
   localparam longint WINDOW_RESET     = 20000000;
   localparam longint FRAME_RATE_RESET = 60;
   localparam longint HOLD_TIME_RESET  = 8000000;

   // Frame rate thresholds and their divisors.
   localparam int FRAME_RATE_MID  = 90;
   localparam int FRAME_RATE_HIGH = 120;
   localparam longint DIV_LOW     = 5;
   localparam longint DIV_MID     = 4;
   localparam longint DIV_HIGH    = 3;

   // factor = window / (divisor * 1 ms) via a rounded-up reciprocal. With a
   // 53-bit shift the result is exact for every 30-bit window.
   localparam int RECIP_SHIFT = 53;
   localparam int RECIP_W     = 32;
   localparam longint RECIP_LOW  = ((64'sd1 <<< RECIP_SHIFT) + DIV_LOW * NS_PER_MS - 1)
                                   / (DIV_LOW * NS_PER_MS);
   localparam longint RECIP_MID  = ((64'sd1 <<< RECIP_SHIFT) + DIV_MID * NS_PER_MS - 1)
                                   / (DIV_MID * NS_PER_MS);
   localparam longint RECIP_HIGH = ((64'sd1 <<< RECIP_SHIFT) + DIV_HIGH * NS_PER_MS - 1)
                                   / (DIV_HIGH * NS_PER_MS);
   localparam longint FACTOR_RESET = (WINDOW_RESET / NS_PER_MS) / DIV_LOW;

   // Input transaction.
   typedef struct packed {
      logic                cmd;
      logic [2:0]          cpu_index;
      logic [TIME_W-1:0]   now;
      logic                slide_scene;
      logic                launcher_scene;
      logic                task_present;
      logic                task_heavy_or_rt;
      logic                task_misfit;
      logic [TIME_W-1:0]   wake_time;
      logic [DEMAND_W-1:0] prev_demand;
      logic [DEMAND_W-1:0] curr_demand;
   } req_item_type;

   // Result transaction.
   typedef struct packed {
      logic [LOAD_W-1:0] boost_load;
      logic              boost_flag;
      logic              reset_flag;
   } rsp_item_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [LOAD_W-1:0]   window_ns;
      logic [LOAD_W-1:0]   hold_time_ns;
      logic [FACTOR_W-1:0] factor;
   } cfg_type;

   // Input register contents, with the timing terms already reduced.
   typedef struct packed {
      logic                 cmd;
      logic [CPU_IDX_W-1:0] cpu;
      logic                 in_range;
      logic [TIME_W-1:0]    now;
      logic                 slide_scene;
      logic                 launcher_scene;
      logic                 task_counts;
      logic                 wake_late;
      logic                 span_big;
      logic [LOAD_W-1:0]    span_lo;
      logic [LOAD_W-1:0]    demand_sat;
   } stage_type;

   // Table write and result from the update logic.
   typedef struct packed {
      logic              wr_en;
      logic [LOAD_W-1:0] load;
      logic [TIME_W-1:0] stamp;
      rsp_item_type      rsp;
   } upd_type;

endpackage

// ===== rtl/pcblt_csr.sv =====
// Configuration registers of the boost load tracker and the per-millisecond
// load factor derived from them. Depends on pcblt_pkg.
module pcblt_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [pcblt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pcblt_pkg::CSR_DATA_W-1:0]     csr_data,
   output pcblt_pkg::cfg_type                   cfg
);

   logic [pcblt_pkg::LOAD_W-1:0]   window_ff;
   logic [pcblt_pkg::RATE_W-1:0]   frame_rate_ff;
   logic [pcblt_pkg::LOAD_W-1:0]   hold_time_ff;
   logic [pcblt_pkg::FACTOR_W-1:0] factor_ff;

   logic [pcblt_pkg::LOAD_W-1:0]   window_new;
   logic [pcblt_pkg::RATE_W-1:0]   rate_new;
   logic [pcblt_pkg::RECIP_W-1:0]  recip;
   logic [pcblt_pkg::LOAD_W+pcblt_pkg::RECIP_W-1:0] product;
   logic                           factor_wr;

   // Values the factor is computed from after this write.
   always_comb begin
      window_new = window_ff;
      rate_new   = frame_rate_ff;
      factor_wr  = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            pcblt_pkg::CSR_WINDOW: begin
               window_new = csr_data[pcblt_pkg::LOAD_W-1:0];
               factor_wr  = 1'b1;
            end
            pcblt_pkg::CSR_FRAME_RATE: begin
               rate_new  = csr_data[pcblt_pkg::RATE_W-1:0];
               factor_wr = 1'b1;
            end
            default: begin
               factor_wr = 1'b0;
            end
         endcase
      end
   end

   // Divide by divisor times one millisecond with a reciprocal multiply.
   always_comb begin
      if (rate_new <= pcblt_pkg::RATE_W'(pcblt_pkg::FRAME_RATE_MID)) begin
         recip = pcblt_pkg::RECIP_W'(pcblt_pkg::RECIP_LOW);
      end else if (rate_new <= pcblt_pkg::RATE_W'(pcblt_pkg::FRAME_RATE_HIGH)) begin
         recip = pcblt_pkg::RECIP_W'(pcblt_pkg::RECIP_MID);
      end else begin
         recip = pcblt_pkg::RECIP_W'(pcblt_pkg::RECIP_HIGH);
      end
      product = (pcblt_pkg::LOAD_W+pcblt_pkg::RECIP_W)'(window_new)
              * (pcblt_pkg::LOAD_W+pcblt_pkg::RECIP_W)'(recip);
   end

   // Register file; a write to an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= pcblt_pkg::LOAD_W'(pcblt_pkg::WINDOW_RESET);
         frame_rate_ff <= pcblt_pkg::RATE_W'(pcblt_pkg::FRAME_RATE_RESET);
         hold_time_ff  <= pcblt_pkg::LOAD_W'(pcblt_pkg::HOLD_TIME_RESET);
         factor_ff     <= pcblt_pkg::FACTOR_W'(pcblt_pkg::FACTOR_RESET);
      end else begin
         window_ff     <= window_new;
         frame_rate_ff <= rate_new;
         if (csr_valid && (csr_index == pcblt_pkg::CSR_HOLD_TIME)) begin
            hold_time_ff <= csr_data[pcblt_pkg::LOAD_W-1:0];
         end
         if (factor_wr) begin
            factor_ff <= product[pcblt_pkg::RECIP_SHIFT +: pcblt_pkg::FACTOR_W];
         end
      end
   end

   assign cfg.window_ns    = window_ff;
   assign cfg.hold_time_ns = hold_time_ff;
   assign cfg.factor       = factor_ff;

endmodule

// ===== rtl/pcblt_update.sv =====
// Per-entry decision logic of the boost load tracker: load estimate,
// update and query rules, table write and result. Depends on pcblt_pkg.
module pcblt_update (
   input  pcblt_pkg::stage_type             stage,
   input  pcblt_pkg::cfg_type               cfg,
   input  logic [pcblt_pkg::LOAD_W-1:0]     entry_load,
   input  logic [pcblt_pkg::TIME_W-1:0]     entry_stamp,
   output pcblt_pkg::upd_type               upd
);

   localparam int PROD_W = pcblt_pkg::LOAD_W + pcblt_pkg::FACTOR_W;

   logic [PROD_W-1:0]             exec_prod;
   logic [pcblt_pkg::LOAD_W-1:0]  exec_load;
   logic [pcblt_pkg::LOAD_W-1:0]  new_load;
   logic [pcblt_pkg::TIME_W-1:0]  age;
   logic                          expired;

   // Execution estimate: time since wake scaled by the factor, capped.
   always_comb begin
      exec_prod = PROD_W'(stage.span_lo) * PROD_W'(cfg.factor);
      if (cfg.factor == '0) begin
         exec_load = '0;
      end else if (stage.span_big || (exec_prod > PROD_W'(cfg.window_ns))) begin
         exec_load = cfg.window_ns;
      end else begin
         exec_load = exec_prod[pcblt_pkg::LOAD_W-1:0];
      end
      if (stage.wake_late) begin
         new_load = '0;
      end else if (exec_load > stage.demand_sat) begin
         new_load = exec_load;
      end else begin
         new_load = stage.demand_sat;
      end
   end

   // Age of the stored load, modulo the clock width.
   assign age     = stage.now - entry_stamp;
   assign expired = (age >= pcblt_pkg::TIME_W'(cfg.hold_time_ns));

   // Update and query rules.
   always_comb begin
      upd = '0;
      upd.load  = entry_load;
      upd.stamp = entry_stamp;
      if (stage.in_range) begin
         if (stage.cmd == pcblt_pkg::CMD_UPDATE) begin
            if (stage.slide_scene || stage.launcher_scene) begin
               if (stage.task_counts) begin
                  upd.wr_en          = 1'b1;
                  upd.load           = new_load;
                  upd.stamp          = stage.now;
                  upd.rsp.boost_flag = 1'b1;
               end else if (entry_load != '0) begin
                  upd.wr_en          = 1'b1;
                  upd.load           = '0;
                  upd.stamp          = stage.now;
                  upd.rsp.reset_flag = 1'b1;
               end
            end else begin
               // No scene: the entry is wiped without a flag.
               upd.wr_en = 1'b1;
               upd.load  = '0;
               upd.stamp = '0;
            end
         end else if (stage.slide_scene && (entry_load != '0)) begin
            if (expired) begin
               upd.wr_en = 1'b1;
               upd.load  = '0;
            end else begin
               upd.rsp.boost_load = entry_load;
            end
         end
      end
   end

endmodule

// ===== rtl/per_cpu_boost_load_tracker.sv =====
// Top level of the per-CPU boost load tracker: input register, load and stamp
// tables, result register. Depends on pcblt_pkg, pcblt_csr and pcblt_update.
//
// Usage:
// - Input channel req_*: one transaction is an update (cmd 0) or a query
//   (cmd 1) for one CPU entry. Every transaction returns exactly one result.
// - Result channel rsp_*: boost_load for queries, boost_flag and reset_flag
//   for updates, in the order the transactions were taken.
// - Configuration channel csr_*: csr_ready is always high; write the window,
//   frame rate and hold time only while no transaction is in flight.
// - Result: when the result side is free, the transaction moves from the input
//   register to the result register, raising rsp_valid, as the table updates.
// - Throughput: one transaction per cycle while rsp_ready is high. The table
//   read, the 30 by 9 bit load multiply and the entry write back complete in
//   the cycle the transaction leaves the input register; the next one sees it.
// - Reset: the tables are cleared and the registers return to a 20 ms
//   window, 60 Hz frame rate and 8 ms hold time; both channels empty.
// - Stall: a waiting result holds in the result register while one more
//   transaction waits in the input register; req_ready then drops.
module per_cpu_boost_load_tracker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  pcblt_pkg::req_item_type          req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output pcblt_pkg::rsp_item_type          rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pcblt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pcblt_pkg::CSR_DATA_W-1:0] csr_data
);

   pcblt_pkg::cfg_type              cfg;
   pcblt_pkg::stage_type            stage_ff;
   pcblt_pkg::stage_type            stage_in;
   pcblt_pkg::upd_type              upd;
   pcblt_pkg::rsp_item_type         rsp_data_ff;
   logic                            stage_valid_ff;
   logic                            rsp_valid_ff;
   logic                            stage_adv;
   logic [pcblt_pkg::LOAD_W-1:0]    load_ff  [pcblt_pkg::CPU_COUNT];
   logic [pcblt_pkg::TIME_W-1:0]    stamp_ff [pcblt_pkg::CPU_COUNT];
   logic [pcblt_pkg::TIME_W:0]      span_full;
   logic [pcblt_pkg::DEMAND_W+1:0]  demand_sum;

   assign csr_ready = 1'b1;

   pcblt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Reduce the timing fields before they enter the input register.
   always_comb begin
      span_full  = {1'b0, req_data.now} - {1'b0, req_data.wake_time};
      demand_sum = ((pcblt_pkg::DEMAND_W+2)'(req_data.prev_demand)
                 + (pcblt_pkg::DEMAND_W+2)'(req_data.curr_demand)) << 1;
      stage_in.cmd            = req_data.cmd;
      stage_in.cpu            = req_data.cpu_index[pcblt_pkg::CPU_IDX_W-1:0];
      stage_in.in_range       = (32'(req_data.cpu_index) < 32'(pcblt_pkg::CPU_COUNT));
      stage_in.now            = req_data.now;
      stage_in.slide_scene    = req_data.slide_scene;
      stage_in.launcher_scene = req_data.launcher_scene;
      stage_in.task_counts    = req_data.task_present && req_data.task_heavy_or_rt
                                && !req_data.task_misfit;
      stage_in.wake_late      = span_full[pcblt_pkg::TIME_W];
      stage_in.span_big       = (span_full[pcblt_pkg::TIME_W-1:0]
                                 >= pcblt_pkg::TIME_W'(cfg.window_ns));
      stage_in.span_lo        = span_full[pcblt_pkg::LOAD_W-1:0];
      if (demand_sum > (pcblt_pkg::DEMAND_W+2)'(cfg.window_ns)) begin
         stage_in.demand_sat = cfg.window_ns;
      end else begin
         stage_in.demand_sat = demand_sum[pcblt_pkg::LOAD_W-1:0];
      end
   end

   // Handshake: the input register moves on whenever the result slot frees.
   assign stage_adv = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            stage_valid_ff <= 1'b1;
         end else if (stage_adv) begin
            stage_valid_ff <= 1'b0;
         end
         if (stage_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_ff <= stage_in;
      end
      if (stage_adv) begin
         rsp_data_ff <= upd.rsp;
      end
   end

   pcblt_update u_update (
      .stage       (stage_ff),
      .cfg         (cfg),
      .entry_load  (load_ff[stage_ff.cpu]),
      .entry_stamp (stamp_ff[stage_ff.cpu]),
      .upd         (upd)
   );

   // Load and stamp tables, written back as the transaction completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pcblt_pkg::CPU_COUNT; i++) begin
            load_ff[i]  <= '0;
            stamp_ff[i] <= '0;
         end
      end else if (stage_adv && upd.wr_en) begin
         load_ff[stage_ff.cpu]  <= upd.load;
         stamp_ff[stage_ff.cpu] <= upd.stamp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/pcblt_checker.sv =====
// Port-level checker of the boost load tracker, bound to the top level.
// Depends on pcblt_pkg and per_cpu_boost_load_tracker_macros.svh.
`include "per_cpu_boost_load_tracker_macros.svh"

module pcblt_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input pcblt_pkg::rsp_item_type rsp_data
);

   logic req_take;
   logic flag_seen;
   logic flag_form_ok;

   assign req_take     = req_valid && req_ready;
   assign flag_seen    = rsp_valid && (rsp_data.boost_flag || rsp_data.reset_flag);
   assign flag_form_ok = (rsp_data.boost_load == '0)
                         && !(rsp_data.boost_flag && rsp_data.reset_flag);

   // A stalled result stays offered.
   `PCBLT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A stalled result keeps its payload.
   `PCBLT_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))

   // Updates carry flags and no load; the two flags never come together.
   `PCBLT_ASSERT_IMPL(a_flag_form, clock, reset, flag_seen, flag_form_ok)

   // Result slot empty: a taken transaction is registered, then rsp_valid rises.
   `PCBLT_ASSERT_IMPL(a_latency, clock, reset, req_take && !rsp_valid, ##2 rsp_valid)

endmodule

bind per_cpu_boost_load_tracker pcblt_checker u_pcblt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== dv/pcblt_load_checker.sv =====
// Checker of the per-CPU boost load tracker: watches the request, result and
// register channels, predicts each result and compares it with the block.
// Depends on pcblt_pkg only.
module pcblt_load_checker
   import pcblt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_item_type         req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_item_type         rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                   pending,
   output int                   errors
);

   // Shadow copy of the tables and the registers.
   logic [LOAD_W-1:0] shadow_load [CPU_COUNT];
   logic [TIME_W-1:0] shadow_stamp [CPU_COUNT];
   logic [LOAD_W-1:0] window_q;
   logic [RATE_W-1:0] rate_q;
   logic [LOAD_W-1:0] hold_q;

   // Results still owed by the block, oldest first.
   rsp_item_type owed_results [$];

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
   endtask

   // Load estimate: zero if the wake time lies after now, else the larger of the
   // scaled run time and twice the demand, each saturated to the window.
   function automatic logic [LOAD_W-1:0] estimate_load(input logic [TIME_W-1:0] now,
                                                       input logic [TIME_W-1:0] wake,
                                                       input logic [DEMAND_W-1:0] prev,
                                                       input logic [DEMAND_W-1:0] curr);
      longint unsigned divisor;
      longint unsigned factor;
      longint unsigned span;
      longint unsigned exec_est;
      longint unsigned demand_est;
      longint unsigned window;
      if (now < wake) return '0;
      window = 64'(window_q);
      if (rate_q <= FRAME_RATE_MID) begin
         divisor = DIV_LOW;
      end else if (rate_q <= FRAME_RATE_HIGH) begin
         divisor = DIV_MID;
      end else begin
         divisor = DIV_HIGH;
      end
      factor = (window / NS_PER_MS) / divisor;
      span   = now - wake;
      // A long span saturates at once; otherwise the product stays small.
      if (factor != 0 && span >= window) begin
         exec_est = window;
      end else begin
         exec_est = span * factor;
         if (exec_est > window) exec_est = window;
      end
      demand_est = (64'(prev) + 64'(curr)) << 1;
      if (demand_est > window) demand_est = window;
      return LOAD_W'((exec_est > demand_est) ? exec_est : demand_est);
   endfunction

   // Applies one transaction to the shadow tables and returns its result.
   function automatic rsp_item_type track_item(input req_item_type item);
      rsp_item_type res;
      int           cpu;
      res = '0;
      cpu = int'(item.cpu_index);
      if (cpu < CPU_COUNT) begin
         if (item.cmd == CMD_UPDATE) begin
            if (item.slide_scene || item.launcher_scene) begin
               if (item.task_present && item.task_heavy_or_rt && !item.task_misfit) begin
                  shadow_load[cpu]  = estimate_load(item.now, item.wake_time,
                                                    item.prev_demand, item.curr_demand);
                  shadow_stamp[cpu] = item.now;
                  res.boost_flag    = 1'b1;
               end else if (shadow_load[cpu] != 0) begin
                  shadow_load[cpu]  = '0;
                  shadow_stamp[cpu] = item.now;
                  res.reset_flag    = 1'b1;
               end
            end else begin
               shadow_load[cpu]  = '0;
               shadow_stamp[cpu] = '0;
            end
         end else if (item.slide_scene && shadow_load[cpu] != 0) begin
            // The age wraps modulo 2^64; an old entry is dropped on query.
            if (item.now - shadow_stamp[cpu] >= hold_q) shadow_load[cpu] = '0;
            res.boost_load = shadow_load[cpu];
         end
      end
      return res;
   endfunction

   // Result check first: a result never belongs to a request taken at the same edge.
   always @(posedge clock) begin : watch
      rsp_item_type want;
      if (reset) begin
         for (int i = 0; i < CPU_COUNT; i++) begin
            shadow_load[i]  = '0;
            shadow_stamp[i] = '0;
         end
         window_q = LOAD_W'(WINDOW_RESET);
         rate_q   = RATE_W'(FRAME_RATE_RESET);
         hold_q   = LOAD_W'(HOLD_TIME_RESET);
         owed_results.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (owed_results.size() == 0) begin
               report_mismatch("result transaction with no request outstanding");
            end else begin
               want = owed_results.pop_front();
               if (rsp_data.boost_load !== want.boost_load)
                  report_mismatch($sformatf("boost_load got %0d expected %0d",
                                            rsp_data.boost_load, want.boost_load));
               if (rsp_data.boost_flag !== want.boost_flag)
                  report_mismatch($sformatf("boost_flag got %b expected %b",
                                            rsp_data.boost_flag, want.boost_flag));
               if (rsp_data.reset_flag !== want.reset_flag)
                  report_mismatch($sformatf("reset_flag got %b expected %b",
                                            rsp_data.reset_flag, want.reset_flag));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW:     window_q = csr_data;
               CSR_FRAME_RATE: rate_q   = csr_data[RATE_W-1:0];
               CSR_HOLD_TIME:  hold_q   = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) owed_results.push_back(track_item(req_data));
      end
      pending = owed_results.size();
   end

endmodule

// ===== dv/tb.sv =====
// Testbench top of the per-CPU boost load tracker: clock, reset, stimulus on the
// request and register channels, result back-pressure and the verdict.
// Depends on pcblt_pkg, per_cpu_boost_load_tracker and pcblt_load_checker.
module tb;
   import pcblt_pkg::*;

   localparam int STALL_LIMIT = 2000;

   // Register index past the end of the list.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_item_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_item_type          rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    pending;
   int                    errors;

   // Stimulus state: a running clock time and the settings now in force.
   longint unsigned sim_now = 64'd1_000_000_000;
   int unsigned     cur_window = 32'(WINDOW_RESET);
   int unsigned     cur_hold = 32'(HOLD_TIME_RESET);
   int unsigned     sent_count;
   int unsigned     cycle_count;
   int unsigned     quiet_cycles;

   per_cpu_boost_load_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   pcblt_load_checker checker_i (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .pending   (pending),
      .errors    (errors)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result back-pressure, broken by recurring calm stretches with rsp_ready high.
   always @(negedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_ready   <= ((cycle_count % 500) < 120) || ($urandom_range(0, 99) >= 18);
   end

   // Watchdog on cycles in which no transaction of any channel completes.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Random request: often a well-formed update from a counting task at a
   // steadily advancing time, with some queries, noise and wild timestamps.
   function automatic req_item_type random_item();
      req_item_type item;
      int unsigned  pick;
      longint unsigned span;
      item.cmd       = ($urandom_range(0, 99) < 35) ? CMD_QUERY : CMD_UPDATE;
      item.cpu_index = 3'($urandom_range(0, 7));
      sim_now        = sim_now + 64'($urandom_range(0, cur_hold / 3 + 1000));
      item.now       = ($urandom_range(0, 99) < 88) ? sim_now : {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (item.cmd == CMD_UPDATE && pick < 70) begin
         {item.slide_scene, item.launcher_scene} = 2'($urandom_range(1, 3));
         item.task_present     = 1'b1;
         item.task_heavy_or_rt = 1'b1;
         item.task_misfit      = 1'b0;
      end else begin
         {item.slide_scene, item.launcher_scene, item.task_present,
          item.task_heavy_or_rt, item.task_misfit} = 5'($urandom_range(0, 31));
         if (item.cmd == CMD_QUERY) item.slide_scene = ($urandom_range(0, 99) < 85);
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         case ($urandom_range(0, 3))
            0, 1:    span = 64'($urandom_range(0, cur_window / 4 + 2));
            2:       span = 64'($urandom_range(0, 2 * cur_window));
            default: span = 64'($urandom);
         endcase
         item.wake_time = item.now - span;
      end else if (pick < 87) begin
         item.wake_time = item.now + 64'($urandom_range(1, 1000));
      end else begin
         item.wake_time = {$urandom, $urandom};
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         item.prev_demand = $urandom_range(0, cur_window / 8);
         item.curr_demand = $urandom_range(0, cur_window / 8);
      end else if (pick < 80) begin
         item.prev_demand = $urandom;
         item.curr_demand = $urandom;
      end else begin
         item.prev_demand = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         item.curr_demand = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      end
      return item;
   endfunction

   function automatic req_item_type make_update(input int cpu, input logic [63:0] now,
                                                input logic [4:0] flags,
                                                input logic [63:0] wake,
                                                input logic [31:0] prev,
                                                input logic [31:0] curr);
      req_item_type item;
      item.cmd       = CMD_UPDATE;
      item.cpu_index = 3'(cpu);
      item.now       = now;
      {item.slide_scene, item.launcher_scene, item.task_present,
       item.task_heavy_or_rt, item.task_misfit} = flags;
      item.wake_time   = wake;
      item.prev_demand = prev;
      item.curr_demand = curr;
      return item;
   endfunction

   // Query with the unused fields left random.
   function automatic req_item_type make_query(input int cpu, input logic [63:0] now,
                                               input logic slide);
      req_item_type item;
      item             = random_item();
      item.cmd         = CMD_QUERY;
      item.cpu_index   = 3'(cpu);
      item.now         = now;
      item.slide_scene = slide;
      return item;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input req_item_type item);
      bit calm;
      calm = ((sent_count % 200) >= 120) && ((sent_count % 200) < 170);
      while (!calm && $urandom_range(0, 99) < 18) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   // Lowers the request and waits until every result has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic apply_settings(input int unsigned window, input logic [9:0] rate,
                                 input int unsigned hold);
      write_reg(CSR_WINDOW, CSR_DATA_W'(window));
      write_reg(CSR_FRAME_RATE, {20'($urandom), rate});
      write_reg(CSR_HOLD_TIME, CSR_DATA_W'(hold));
      csr_valid  <= 1'b0;
      cur_window = window;
      cur_hold   = hold;
   endtask

   task automatic run_random(input int count);
      repeat (count) send_item(random_item());
      settle();
   endtask

   // Flag order: slide, launcher, present, heavy or real-time, misfit.
   localparam logic [4:0] SLIDE_COUNTING    = 5'b10110;
   localparam logic [4:0] LAUNCHER_COUNTING = 5'b01110;
   localparam logic [4:0] NO_SCENE_COUNTING = 5'b00110;
   localparam logic [4:0] SLIDE_MISFIT      = 5'b10111;
   localparam logic [4:0] SLIDE_NO_TASK     = 5'b10010;
   localparam logic [4:0] SLIDE_LIGHT_TASK  = 5'b10100;

   initial begin
      logic [63:0] t0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      t0        = 64'd1_000_000_000;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset settings: 20 ms window, 60 Hz, 8 ms hold.
      send_item(make_query(0, t0, 1'b1));
      send_item(make_update(0, t0, SLIDE_COUNTING, t0 - 1_000_000, 0, 0));
      // Just inside and exactly at the hold time.
      send_item(make_query(0, t0 + 7_999_999, 1'b1));
      send_item(make_query(0, t0 + 100, 1'b0));
      send_item(make_query(0, t0 + 8_000_000, 1'b1));
      send_item(make_query(0, t0 + 8_000_001, 1'b1));
      // Demand sum overflowing 32 bits saturates to the window.
      send_item(make_update(1, t0, LAUNCHER_COUNTING, t0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_item(make_update(1, t0 + 5, SLIDE_MISFIT, t0, 0, 0));
      send_item(make_update(1, t0 + 6, SLIDE_MISFIT, t0, 0, 0));
      // Wake time after now gives a zero load that still requests a boost.
      send_item(make_update(2, t0, SLIDE_COUNTING, t0 + 1, 32'hFFFF_FFFF, 0));
      send_item(make_query(2, t0, 1'b1));
      send_item(make_update(3, t0, SLIDE_COUNTING, 64'd0, 0, 0));
      send_item(make_update(3, t0 + 1, NO_SCENE_COUNTING, 64'd0, 0, 0));
      send_item(make_query(3, t0 + 2, 1'b1));
      // Extreme timestamps; the query age wraps around zero.
      send_item(make_update(7, '1, SLIDE_COUNTING, 64'd0, 0, 0));
      send_item(make_query(7, 64'd0, 1'b1));
      send_item(make_update(7, 64'd5, SLIDE_NO_TASK, 64'd0, 0, 0));
      send_item(make_update(6, t0, LAUNCHER_COUNTING, t0 - 100, 7, 9));
      send_item(make_update(6, t0 + 1, SLIDE_LIGHT_TASK, t0, 0, 0));
      send_item(make_update(5, t0, SLIDE_COUNTING, t0, 1, 2));
      send_item(make_query(5, t0 + 10, 1'b1));
      send_item(make_update(4, t0, SLIDE_COUNTING, t0 - 2_000_000, 32'h7FFF_FFFF, 0));
      settle();

      run_random(150);
      // Largest window, highest rate, zero hold.
      apply_settings(1_000_000_000, 10'd1000, 0);
      run_random(80);
      // One-millisecond window at the 90 Hz edge, longest hold.
      apply_settings(1_000_000, 10'd90, 1_000_000_000);
      run_random(80);
      // Window below one millisecond: the run-time factor becomes zero.
      apply_settings(999_999, 10'd121, $urandom_range(0, 20_000_000));
      run_random(70);
      // A write to the unused register index must change nothing.
      write_reg(CSR_UNUSED, 30'($urandom));
      apply_settings($urandom_range(1_000_000, 1_000_000_000), 10'($urandom_range(91, 120)),
                     $urandom_range(0, 1_000_000_000));
      run_random(80);
      apply_settings(20_000_000, 10'd120, 8_000_000);
      run_random(80);
      apply_settings($urandom_range(1_000_000, 100_000_000), 10'd0, 1);
      run_random(80);

      repeat (8) @(negedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
